// File: hw/rtl/wsst_pkg.sv
// Shared types and constants for the work/span stack tracker.
`default_nettype none
package wsst_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_TIME_WIDTH  = 48;
	localparam int BURDEN_W        = 32;
	localparam int CFG_INDEX_W     = 1;

	localparam logic [3:0] CMD_FUNC_ENTRY   = 4'd0;
	localparam logic [3:0] CMD_FUNC_EXIT    = 4'd1;
	localparam logic [3:0] CMD_DETACH       = 4'd2;
	localparam logic [3:0] CMD_TASK         = 4'd3;
	localparam logic [3:0] CMD_TASK_EXIT    = 4'd4;
	localparam logic [3:0] CMD_DETACH_CONT  = 4'd5;
	localparam logic [3:0] CMD_BEFORE_SYNC  = 4'd6;
	localparam logic [3:0] CMD_AFTER_SYNC   = 4'd7;
	localparam logic [3:0] CMD_PROBE        = 4'd8;

	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_SPAWN_BURDEN    = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TRACKING_ENABLE = 1'd1;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLOSE,
		OP_PUSH_CLOSE,
		OP_PUSH,
		OP_POP_FUNC,
		OP_POP_TASK,
		OP_BURDEN,
		OP_MERGE
	} op_t;

	typedef struct packed {
		logic [3:0]  command;
		logic        event_flag;
		logic [31:0] strand_time;
	} in_t;

	typedef struct packed {
		logic [47:0] total_work;
		logic [47:0] total_span;
		logic [47:0] total_bspan;
		logic [6:0]  stack_depth;
		logic [1:0]  error_code;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic       rd;
		logic       apply;
		logic       pop_phase;
		op_t        op;
		logic [1:0] err;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic enable;
	} st_t;

endpackage
`default_nettype wire

// File: hw/rtl/work_span_stack_tracker.sv
// Top level of the work/span stack tracker.
//
//   channel  direction  handshake               payload
//   in       request    in_valid / in_stall     in_data  (wsst_pkg::in_t)
//   out      result     out_valid / out_stall   out_data (wsst_pkg::out_t)
//   cfg      write      cfg_we                  cfg_index, cfg_data
//
// Pops (function exit, task exit) stall the input for a separate write-back phase,
// since the parent frame is read from the stack RAM with a registered read port.
// The top frame lives in registers; the RAM holds only the frames below it.
// Reset clears the top frame and depth; no clearing pass is needed.
// A new request is taken while no pop is pending and the result register is empty or being drained.
`default_nettype none
module work_span_stack_tracker #(
	parameter int STACK_DEPTH = wsst_pkg::DEF_STACK_DEPTH,
	parameter int TIME_WIDTH  = wsst_pkg::DEF_TIME_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire wsst_pkg::in_t                    in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output wsst_pkg::out_t                        out_data,
	input  wire logic                             cfg_we,
	input  wire logic [wsst_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [wsst_pkg::BURDEN_W-1:0]    cfg_data
);
	import wsst_pkg::*;

	ctl_t ctl;
	st_t  st;

	wsst_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (in_data.command),
		.event_flag (in_data.event_flag),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.st         (st),
		.ctl        (ctl)
	);

	wsst_dp #(.STACK_DEPTH(STACK_DEPTH), .TIME_WIDTH(TIME_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.ctl       (ctl),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.st        (st),
		.out_data  (out_data)
	);

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.error_code == ERR_OVERFLOW)
		|-> (out_data.stack_depth == 7'(STACK_DEPTH)))
		else $error("overflow reported below full depth");

	a_underflow_base: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.error_code == ERR_UNDERFLOW)
		|-> (out_data.stack_depth == '0))
		else $error("underflow reported above base frame");

	a_pop_completes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd |=> (ctl.apply && ctl.pop_phase && in_stall))
		else $error("pop read not followed by write-back");

	a_no_double_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd |-> !ctl.apply)
		else $error("stack read and frame update in same cycle");
endmodule
`default_nettype wire

// File: hw/rtl/wsst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wsst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/wsst_ctrl.sv
// Controller: event decode, handshake and pop sequencing.
`default_nettype none
module wsst_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [3:0]      command,
	input  wire logic            event_flag,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire wsst_pkg::st_t   st,
	output wsst_pkg::ctl_t       ctl
);
	import wsst_pkg::*;

	typedef enum logic [0:0] {S_IDLE, S_POP} state_t;

	state_t     state_q;
	op_t        op_q;
	op_t        dec_op;
	logic [1:0] dec_err;
	logic       busy;
	logic       accept;
	logic       dec_pop;

	always_comb begin
		dec_op  = OP_NONE;
		dec_err = ERR_OK;
		unique case (command)
			CMD_FUNC_ENTRY: begin
				if (st.enable && event_flag) begin
					if (st.full) dec_err = ERR_OVERFLOW;
					else dec_op = OP_PUSH_CLOSE;
				end
			end
			CMD_FUNC_EXIT: begin
				if (st.enable && event_flag) begin
					if (st.empty) dec_err = ERR_UNDERFLOW;
					else dec_op = OP_POP_FUNC;
				end
			end
			CMD_DETACH, CMD_BEFORE_SYNC, CMD_PROBE: dec_op = OP_CLOSE;
			CMD_TASK: begin
				if (st.full) dec_err = ERR_OVERFLOW;
				else dec_op = OP_PUSH;
			end
			CMD_TASK_EXIT: begin
				if (st.empty) dec_err = ERR_UNDERFLOW;
				else dec_op = OP_POP_TASK;
			end
			CMD_DETACH_CONT: dec_op = event_flag ? OP_MERGE : OP_BURDEN;
			CMD_AFTER_SYNC:  dec_op = OP_MERGE;
			default:         dec_op = OP_NONE;
		endcase
	end

	assign busy     = (state_q == S_POP);
	assign in_stall = busy || (out_valid && out_stall);
	assign accept   = in_valid && !in_stall;
	assign dec_pop  = (dec_op == OP_POP_FUNC) || (dec_op == OP_POP_TASK);

	always_comb begin
		ctl.rd        = accept && dec_pop;
		ctl.apply     = (accept && !dec_pop) || busy;
		ctl.pop_phase = busy;
		ctl.op        = busy ? op_q : dec_op;
		ctl.err       = busy ? ERR_OK : dec_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_NONE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && dec_pop) begin
						op_q    <= dec_op;
						state_q <= S_POP;
					end
				end
				S_POP: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (ctl.apply) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/wsst_dp.sv
// Datapath: top frame registers, parent frame stack, config and result register.
`default_nettype none
module wsst_dp #(
	parameter int STACK_DEPTH = wsst_pkg::DEF_STACK_DEPTH,
	parameter int TIME_WIDTH  = wsst_pkg::DEF_TIME_WIDTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire wsst_pkg::in_t                       in_data,
	input  wire wsst_pkg::ctl_t                      ctl,
	input  wire logic                                cfg_we,
	input  wire logic [wsst_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [wsst_pkg::BURDEN_W-1:0]       cfg_data,
	output wsst_pkg::st_t                            st,
	output wsst_pkg::out_t                           out_data
);
	import wsst_pkg::*;

	localparam int TW    = TIME_WIDTH;
	localparam int TOP_W = $clog2(STACK_DEPTH + 1);
	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int FW    = 6 * TW;

	logic [TW-1:0] cw_q, cs_q, cb_q, chw_q, lcs_q, lcb_q;
	logic [TW-1:0] n_cw, n_cs, n_cb, n_chw, n_lcs, n_lcb;
	logic [TW-1:0] p_cw, p_cs, p_cb, p_chw, p_lcs, p_lcb;
	logic [TW-1:0] tt, burden, k_cw, k_cs, k_cb, k_cbb;
	logic [TOP_W-1:0] top_q, n_top;
	logic [31:0]   t_q;
	logic [BURDEN_W-1:0] burden_q;
	logic          enable_q;
	logic [FW-1:0] rdata;
	logic          we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burden_q <= '0;
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPAWN_BURDEN:    burden_q <= cfg_data;
				REG_TRACKING_ENABLE: enable_q <= cfg_data[0];
				default:             ;
			endcase
		end
	end

	assign st.full   = (top_q == TOP_W'(STACK_DEPTH));
	assign st.empty  = (top_q == '0);
	assign st.enable = enable_q;

	assign {p_cw, p_cs, p_cb, p_chw, p_lcs, p_lcb} = rdata;

	assign tt     = TW'(ctl.pop_phase ? t_q : in_data.strand_time);
	assign burden = TW'(burden_q);
	// child frame after closing its strand
	assign k_cw  = cw_q + tt;
	assign k_cs  = cs_q + tt;
	assign k_cb  = cb_q + tt;
	assign k_cbb = k_cb + burden;

	always_comb begin
		n_cw = cw_q; n_cs = cs_q; n_cb = cb_q;
		n_chw = chw_q; n_lcs = lcs_q; n_lcb = lcb_q;
		n_top = top_q;
		unique case (ctl.op)
			OP_CLOSE: begin
				n_cw = k_cw; n_cs = k_cs; n_cb = k_cb;
			end
			OP_PUSH_CLOSE: begin
				n_cw = k_cw; n_cs = k_cs; n_cb = k_cb;
				n_chw = '0; n_lcs = '0; n_lcb = '0;
				n_top = top_q + 1'b1;
			end
			OP_PUSH: begin
				n_chw = '0; n_lcs = '0; n_lcb = '0;
				n_top = top_q + 1'b1;
			end
			OP_POP_FUNC: begin
				n_cw = k_cw; n_cs = k_cs; n_cb = k_cb;
				n_chw = p_chw; n_lcs = p_lcs; n_lcb = p_lcb;
				n_top = top_q - 1'b1;
			end
			OP_POP_TASK: begin
				n_cw  = p_cw; n_cs = p_cs; n_cb = p_cb;
				n_chw = p_chw + k_cw - p_cw;
				n_lcs = (k_cs > p_lcs) ? k_cs : p_lcs;
				n_lcb = (k_cbb > p_lcb) ? k_cbb : p_lcb;
				n_top = top_q - 1'b1;
			end
			OP_BURDEN: n_cb = cb_q + burden;
			OP_MERGE: begin
				n_cw = cw_q + chw_q;
				n_cs = (lcs_q > cs_q) ? lcs_q : cs_q;
				n_cb = (lcb_q > cb_q) ? lcb_q : cb_q;
				n_chw = '0; n_lcs = '0; n_lcb = '0;
			end
			default: ;
		endcase
	end

	// save the parent below the new top (closed first for a function entry)
	assign we = ctl.apply && ((ctl.op == OP_PUSH) || (ctl.op == OP_PUSH_CLOSE));

	wsst_ram #(.WIDTH(FW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (top_q[AW-1:0]),
		.wdata ({n_cw, n_cs, n_cb, chw_q, lcs_q, lcb_q}),
		.re    (ctl.rd),
		.raddr (AW'(top_q - 1'b1)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			cw_q <= '0; cs_q <= '0; cb_q <= '0;
			chw_q <= '0; lcs_q <= '0; lcb_q <= '0;
		end else if (ctl.apply) begin
			top_q <= n_top;
			cw_q <= n_cw; cs_q <= n_cs; cb_q <= n_cb;
			chw_q <= n_chw; lcs_q <= n_lcs; lcb_q <= n_lcb;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) t_q <= in_data.strand_time;
		if (ctl.apply) begin
			out_data.total_work  <= 48'(n_cw);
			out_data.total_span  <= 48'(n_cs);
			out_data.total_bspan <= 48'(n_cb);
			out_data.stack_depth <= 7'(n_top);
			out_data.error_code  <= ctl.err;
		end
	end
endmodule
`default_nettype wire

// File: dv/tb_work_span_stack_tracker.sv
// Self-checking testbench for the work/span stack tracker.
`timescale 1ns / 1ps
`default_nettype none
module tb_work_span_stack_tracker;
	import wsst_pkg::*;

	localparam int DEPTH    = DEF_STACK_DEPTH;
	localparam int WATCHDOG = 20000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [BURDEN_W-1:0] cfg_data = '0;

	always #2 clk = ~clk;

	work_span_stack_tracker u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow frame stack
	logic [47:0] cw[DEPTH+1], cs[DEPTH+1], cb[DEPTH+1];
	logic [47:0] kw[DEPTH+1], ks[DEPTH+1], kb[DEPTH+1];
	int unsigned top_idx;
	logic [47:0] burden_sh;
	logic track_sh;

	in_t request_q[$];
	out_t totals_q[$];
	int unsigned errors = 0;
	int unsigned sent = 0;
	int unsigned received = 0;
	int unsigned idle_cycles = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int unsigned hold_left = 0;

	function automatic logic [47:0] ext(logic [31:0] v);
		return {16'd0, v};
	endfunction

	function automatic void close_top(logic [31:0] t);
		cw[top_idx] += ext(t);
		cs[top_idx] += ext(t);
		cb[top_idx] += ext(t);
	endfunction

	function automatic void push_top();
		int unsigned c;
		c = top_idx + 1;
		cw[c] = cw[top_idx]; cs[c] = cs[top_idx]; cb[c] = cb[top_idx];
		kw[c] = '0; ks[c] = '0; kb[c] = '0;
		top_idx = c;
	endfunction

	function automatic void merge_top();
		cw[top_idx] += kw[top_idx];
		kw[top_idx] = '0;
		if (ks[top_idx] > cs[top_idx]) cs[top_idx] = ks[top_idx];
		ks[top_idx] = '0;
		if (kb[top_idx] > cb[top_idx]) cb[top_idx] = kb[top_idx];
		kb[top_idx] = '0;
	endfunction

	function automatic out_t predict_totals(in_t r);
		out_t o;
		logic [1:0] err;
		int unsigned p;
		logic [47:0] bt;
		err = ERR_OK;
		p = top_idx - 1;
		case (r.command)
			CMD_FUNC_ENTRY:
				if (track_sh && r.event_flag) begin
					if (top_idx >= DEPTH) err = ERR_OVERFLOW;
					else begin
						close_top(r.strand_time);
						push_top();
					end
				end
			CMD_FUNC_EXIT:
				if (track_sh && r.event_flag) begin
					if (top_idx == 0) err = ERR_UNDERFLOW;
					else begin
						cw[p] = cw[top_idx] + ext(r.strand_time);
						cs[p] = cs[top_idx] + ext(r.strand_time);
						cb[p] = cb[top_idx] + ext(r.strand_time);
						top_idx = p;
					end
				end
			CMD_DETACH, CMD_BEFORE_SYNC, CMD_PROBE: close_top(r.strand_time);
			CMD_TASK:
				if (top_idx >= DEPTH) err = ERR_OVERFLOW;
				else push_top();
			CMD_TASK_EXIT:
				if (top_idx == 0) err = ERR_UNDERFLOW;
				else begin
					close_top(r.strand_time);
					kw[p] = kw[p] + cw[top_idx] - cw[p];
					if (cs[top_idx] > ks[p]) ks[p] = cs[top_idx];
					bt = cb[top_idx] + burden_sh;
					if (bt > kb[p]) kb[p] = bt;
					top_idx = p;
				end
			CMD_DETACH_CONT:
				if (r.event_flag) merge_top();
				else cb[top_idx] += burden_sh;
			CMD_AFTER_SYNC: merge_top();
			default: ;
		endcase
		o.total_work = cw[top_idx];
		o.total_span = cs[top_idx];
		o.total_bspan = cb[top_idx];
		o.stack_depth = 7'(top_idx);
		o.error_code = err;
		return o;
	endfunction

	function automatic in_t mk(logic [3:0] c, logic f, logic [31:0] t);
		in_t r;
		r.command = c; r.event_flag = f; r.strand_time = t;
		return r;
	endfunction

	function automatic logic [31:0] rnd_time();
		case ($urandom_range(0, 3))
			0: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
			1: return 32'($urandom_range(0, 100));
			default: return $urandom;
		endcase
	endfunction

	// driver
	int unsigned send_gap = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			totals_q.push_back(predict_totals(in_data));
			sent++;
		end
		if (in_valid && in_stall) begin
			// hold the stalled request
		end else if (send_gap != 0) begin
			send_gap <= send_gap - 1;
			in_valid <= 1'b0;
		end else if (request_q.size() != 0 && arst_n) begin
			in_data <= request_q.pop_front();
			in_valid <= 1'b1;
			send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
		end else
			in_valid <= 1'b0;
	end

	// monitor
	int unsigned recv_gap = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			received++;
			if (totals_q.size() == 0) begin
				$display("%0t: unexpected result expected none actual %h", $time, out_data);
				errors++;
			end else begin
				out_t e;
				e = totals_q.pop_front();
				if (e !== out_data) begin
					$display("%0t: mismatch expected %h actual %h", $time, e, out_data);
					errors++;
				end
			end
			recv_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
		end
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (recv_gap != 0) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_left != 0)
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("work_span_stack_tracker verification failed");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SPAWN_BURDEN) burden_sh = ext(v);
		else track_sh = v[0];
	endtask

	task automatic drain();
		while (request_q.size() != 0 || in_valid || totals_q.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// random mix of push, pop and other events; a depth count is kept but nesting is not kept well-formed
	task automatic queue_random(int unsigned n);
		int unsigned d;
		int unsigned k;
		d = top_idx;
		for (k = 0; k < n; k++) begin
			int unsigned s;
			s = $urandom_range(0, 99);
			if (s < 5)
				request_q.push_back(mk(4'($urandom_range(0, 15)), 1'($urandom), rnd_time()));
			else if (s < 30 && d < DEPTH + 1) begin
				request_q.push_back(mk($urandom_range(0, 1) ? CMD_TASK : CMD_FUNC_ENTRY,
					1'($urandom_range(0, 7) != 0), rnd_time()));
				if (d < DEPTH) d++;
			end else if (s < 55) begin
				request_q.push_back(mk($urandom_range(0, 1) ? CMD_TASK_EXIT : CMD_FUNC_EXIT,
					1'($urandom_range(0, 7) != 0), rnd_time()));
				if (d > 0) d--;
			end else
				request_q.push_back(mk(4'($urandom_range(2, 8)), 1'($urandom), rnd_time()));
		end
	endtask

	initial begin
		int unsigned i;
		for (i = 0; i <= DEPTH; i++) begin
			cw[i] = '0; cs[i] = '0; cb[i] = '0; kw[i] = '0; ks[i] = '0; kb[i] = '0;
		end
		top_idx = 0; burden_sh = '0; track_sh = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// tracking off: function events ignored, task exit at base underflows
		request_q.push_back(mk(CMD_FUNC_ENTRY, 1'b1, 32'hFFFF_FFFF));
		request_q.push_back(mk(CMD_FUNC_EXIT, 1'b1, 32'd5));
		request_q.push_back(mk(CMD_TASK_EXIT, 1'b0, 32'd7));
		request_q.push_back(mk(4'd15, 1'b1, 32'd9));
		request_q.push_back(mk(4'd9, 1'b0, 32'd9));
		drain();
		write_reg(REG_TRACKING_ENABLE, 32'd1);
		write_reg(REG_SPAWN_BURDEN, 32'hFFFF_FFFF);
		request_q.push_back(mk(CMD_FUNC_ENTRY, 1'b0, 32'd3));
		request_q.push_back(mk(CMD_FUNC_ENTRY, 1'b1, 32'hFFFF_FFFF));
		request_q.push_back(mk(CMD_DETACH, 1'b0, 32'd10));
		request_q.push_back(mk(CMD_TASK, 1'b0, 32'd0));
		request_q.push_back(mk(CMD_PROBE, 1'b1, 32'hFFFF_FFFF));
		request_q.push_back(mk(CMD_TASK_EXIT, 1'b1, 32'd20));
		request_q.push_back(mk(CMD_DETACH_CONT, 1'b0, 32'd0));
		request_q.push_back(mk(CMD_BEFORE_SYNC, 1'b0, 32'd1));
		request_q.push_back(mk(CMD_AFTER_SYNC, 1'b0, 32'd0));
		request_q.push_back(mk(CMD_TASK, 1'b0, 32'd0));
		request_q.push_back(mk(CMD_TASK_EXIT, 1'b0, 32'd2));
		request_q.push_back(mk(CMD_DETACH_CONT, 1'b1, 32'd0));
		request_q.push_back(mk(CMD_FUNC_EXIT, 1'b0, 32'd4));
		request_q.push_back(mk(CMD_FUNC_EXIT, 1'b1, 32'hFFFF_FFFF));
		// fill to the top, overflow, then unwind to base and underflow
		for (i = 0; i <= DEPTH; i++) request_q.push_back(mk(CMD_TASK, 1'b0, 32'd0));
		request_q.push_back(mk(CMD_FUNC_ENTRY, 1'b1, 32'd1));
		for (i = 0; i <= DEPTH; i++) request_q.push_back(mk(CMD_TASK_EXIT, 1'b0, rnd_time()));
		drain();

		// long receiver hold while the sender keeps offering
		queue_random(60);
		repeat (20) @(posedge clk);
		hold_req <= 1'b1;
		drain();

		write_reg(REG_SPAWN_BURDEN, 32'd0);
		queue_random(300);
		drain();
		write_reg(REG_TRACKING_ENABLE, 32'd0);
		write_reg(REG_SPAWN_BURDEN, $urandom);
		queue_random(250);
		drain();
		write_reg(REG_TRACKING_ENABLE, 32'd1);
		write_reg(REG_SPAWN_BURDEN, 32'hFFFF_FFFF);
		queue_random(290);
		drain();

		if (errors == 0)
			$display("work_span_stack_tracker verification clean");
		else
			$display("work_span_stack_tracker verification failed");
		$finish;
	end
endmodule
`default_nettype wire
